>>> hw/rtl/bsd_pkg.sv
// shared types and constants for the byte-stuffed deframer
`timescale 1ns / 1ps

package bsd_pkg;

  localparam logic [7:0] START_SYM = 8'h23;  // '#'
  localparam logic [7:0] ESC_SYM   = 8'h3F;  // '?'
  localparam logic [7:0] ESC_XOR   = 8'h20;

  typedef enum logic [1:0] {
    KIND_DATA = 2'd0,
    KIND_GOOD = 2'd1,
    KIND_BAD  = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  data_byte;
    logic [7:0]  frame_id;
    logic [15:0] frame_size;
  } result_t;

endpackage

>>> hw/rtl/bsd_in_reg.sv
// input register stage with stall back to the link side
`timescale 1ns / 1ps

module bsd_in_reg
  import bsd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       rx_valid,
  output logic       rx_stall,
  input  logic [7:0] rx_byte,
  input  logic       advance,
  output logic       held_valid,
  output logic [7:0] held_byte
);

  logic load;

  // take a new byte when empty or when the held one moves on
  assign rx_stall = held_valid && !advance;
  assign load     = rx_valid && !rx_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (load) begin
      held_valid <= 1'b1;
    end else if (advance) begin
      held_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held_byte <= rx_byte;
    end
  end

endmodule

>>> hw/rtl/bsd_parser.sv
// frame state machine: un-escape, header capture, payload count, checksum
`timescale 1ns / 1ps

module bsd_parser
  import bsd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       advance,
  input  logic [7:0] raw_byte,
  output logic       hit,
  output result_t    result
);

  typedef enum logic [2:0] {
    PH_WAIT    = 3'd0,
    PH_ID      = 3'd1,
    PH_SIZE_LO = 3'd2,
    PH_SIZE_HI = 3'd3,
    PH_PAYLOAD = 3'd4,
    PH_CHECK   = 3'd5
  } phase_t;

  phase_t      phase, phase_next;
  logic        escape_pending, escape_pending_next;
  logic [7:0]  sum_acc, sum_acc_next;
  logic [7:0]  id_reg, id_reg_next;
  logic [15:0] size_reg, size_reg_next;
  logic [15:0] bytes_left, bytes_left_next;
  logic [7:0]  b;

  always_comb begin
    phase_next          = phase;
    escape_pending_next = escape_pending;
    sum_acc_next        = sum_acc;
    id_reg_next         = id_reg;
    size_reg_next       = size_reg;
    bytes_left_next     = bytes_left;
    hit                 = 1'b0;
    b                   = escape_pending ? (raw_byte ^ ESC_XOR) : raw_byte;
    result.kind         = KIND_DATA;
    result.data_byte    = b;
    result.frame_id     = id_reg;
    result.frame_size   = size_reg;

    if (raw_byte == START_SYM) begin
      phase_next          = PH_ID;
      escape_pending_next = 1'b0;
      sum_acc_next        = 8'd0;
      id_reg_next         = 8'd0;
      size_reg_next       = 16'd0;
      bytes_left_next     = 16'd0;
    end else if (raw_byte == ESC_SYM) begin
      escape_pending_next = 1'b1;
    end else begin
      escape_pending_next = 1'b0;
      sum_acc_next        = sum_acc + b;
      case (phase)
        PH_ID: begin
          id_reg_next = b;
          phase_next  = PH_SIZE_LO;
        end
        PH_SIZE_LO: begin
          size_reg_next = {size_reg[15:8], b};
          phase_next    = PH_SIZE_HI;
        end
        PH_SIZE_HI: begin
          size_reg_next   = {b, size_reg[7:0]};
          bytes_left_next = {b, size_reg[7:0]};
          // empty payload goes straight to the checksum byte
          phase_next = ({b, size_reg[7:0]} == 16'd0) ? PH_CHECK : PH_PAYLOAD;
        end
        PH_PAYLOAD: begin
          hit             = 1'b1;
          bytes_left_next = bytes_left - 16'd1;
          if (bytes_left == 16'd1) begin
            phase_next = PH_CHECK;
          end
        end
        PH_CHECK: begin
          hit              = 1'b1;
          result.kind      = (sum_acc_next == 8'd0) ? KIND_GOOD : KIND_BAD;
          result.data_byte = 8'd0;
          phase_next       = PH_WAIT;
        end
        default: begin
          // waiting for start: content is dropped
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_WAIT;
      escape_pending <= 1'b0;
      sum_acc        <= 8'd0;
      id_reg         <= 8'd0;
      size_reg       <= 16'd0;
      bytes_left     <= 16'd0;
    end else if (advance) begin
      phase          <= phase_next;
      escape_pending <= escape_pending_next;
      sum_acc        <= sum_acc_next;
      id_reg         <= id_reg_next;
      size_reg       <= size_reg_next;
      bytes_left     <= bytes_left_next;
    end
  end

endmodule

>>> hw/rtl/bsd_out_reg.sv
// result register toward the consumer
`timescale 1ns / 1ps

module bsd_out_reg
  import bsd_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    load,
  input  result_t load_result,
  output logic    can_load,
  output logic    res_valid,
  input  logic    res_stall,
  output result_t res
);

  // free when empty or when the current result leaves this cycle
  assign can_load = !res_valid || !res_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (can_load) begin
      res_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (can_load && load) begin
      res <= load_result;
    end
  end

endmodule

>>> hw/rtl/byte_stuffed_packet_deframer_unit.sv
// top level of the byte-stuffed packet deframer
`timescale 1ns / 1ps

// Receives one raw link byte per rx transfer and emits at most one result per
// byte. '#' starts a frame and clears all state; '?' escapes the next byte,
// which is XORed with 0x20. Frame layout after un-escaping: id byte, 16-bit
// size low byte first, payload, checksum byte; the 8-bit sum of all content
// bytes including the checksum must be zero. Each payload byte yields a
// result of kind 0; the checksum byte yields kind 1 (good) or 2 (bad) with
// data_byte zero. frame_id and frame_size always carry the current header.
// A frame cut by '#' restarts without a frame-end result, so payload with no
// good frame end should be discarded downstream. Throughput is one byte per
// clock while the result register is not full and stalled. A byte is held
// in the input register and, once the result register has room, advances:
// the parser updates its state and the result is loaded into the result
// register. rx_stall rises only while the result register is full and
// stalled. Start, escape, header and out-of-frame bytes produce no result.

module byte_stuffed_packet_deframer_unit
  import bsd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        rx_valid,
  output logic        rx_stall,
  input  logic [7:0]  rx_byte,
  output logic        res_valid,
  input  logic        res_stall,
  output logic [1:0]  kind,
  output logic [7:0]  data_byte,
  output logic [7:0]  frame_id,
  output logic [15:0] frame_size
);

  logic       held_valid;
  logic [7:0] held_byte;
  logic       can_load;
  logic       advance;
  logic       hit;
  result_t    parsed;
  result_t    res;

  // the held byte moves on once the result register has room
  assign advance = held_valid && can_load;

  bsd_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .rx_valid   (rx_valid),
    .rx_stall   (rx_stall),
    .rx_byte    (rx_byte),
    .advance    (advance),
    .held_valid (held_valid),
    .held_byte  (held_byte)
  );

  bsd_parser u_parser (
    .clk      (clk),
    .rst      (rst),
    .advance  (advance),
    .raw_byte (held_byte),
    .hit      (hit),
    .result   (parsed)
  );

  bsd_out_reg u_out_reg (
    .clk         (clk),
    .rst         (rst),
    .load        (advance && hit),
    .load_result (parsed),
    .can_load    (can_load),
    .res_valid   (res_valid),
    .res_stall   (res_stall),
    .res         (res)
  );

  assign kind       = res.kind;
  assign data_byte  = res.data_byte;
  assign frame_id   = res.frame_id;
  assign frame_size = res.frame_size;

endmodule

>>> hw/rtl/bsd_checker.sv
// port-level checks for the deframer, bound to the top level
`timescale 1ns / 1ps

module bsd_checker
  import bsd_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        rx_stall,
  input logic        res_valid,
  input logic        res_stall,
  input logic [1:0]  kind,
  input logic [7:0]  data_byte,
  input logic [7:0]  frame_id,
  input logic [15:0] frame_size
);

  // rx side only backs up when the result side is full and stalled
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    rx_stall |-> (res_valid && res_stall))
    else $error("rx stall without a stalled result");

  a_kind_legal: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (kind == KIND_DATA || kind == KIND_GOOD || kind == KIND_BAD))
    else $error("illegal result kind");

  a_end_data_zero: assert property (@(posedge clk) disable iff (rst)
    (res_valid && kind != KIND_DATA) |-> (data_byte == 8'd0))
    else $error("frame end with nonzero data byte");

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_stall) |=> (res_valid && $stable(kind) && $stable(data_byte)
      && $stable(frame_id) && $stable(frame_size)))
    else $error("stalled result changed");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !res_valid)
    else $error("result valid right after reset");

endmodule

bind byte_stuffed_packet_deframer_unit bsd_checker u_bsd_checker (
  .clk        (clk),
  .rst        (rst),
  .rx_stall   (rx_stall),
  .res_valid  (res_valid),
  .res_stall  (res_stall),
  .kind       (kind),
  .data_byte  (data_byte),
  .frame_id   (frame_id),
  .frame_size (frame_size)
);
